// ----- rtl/mfde_pkg.sv -----
package mfde_pkg;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] radius;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } t_rsp;

    localparam logic [2:0] REQ_SET    = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_LINE   = 3'd2;
    localparam logic [2:0] REQ_CIRCLE = 3'd3;
    localparam logic [2:0] REQ_WIPE   = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    localparam int SLOPE_SCALE = 10;

endpackage

// ----- rtl/mfde_div.sv -----
// Restoring divider, one quotient bit per cycle. Quotient truncated to 8 bits.
module mfde_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [11:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [7:0]  o_quo
);
    logic [11:0] r_num;
    logic [8:0]  r_rem;
    logic [7:0]  r_den;
    logic [3:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [9:0]  n_try;
    logic [8:0]  n_shift;

    always_comb begin
        n_shift = {r_rem[7:0], r_num[11]};
        n_try   = {1'b0, n_shift} - {2'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= 4'd0;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end else if (r_run) begin
                r_num <= {r_num[10:0], ~n_try[9]};
                r_rem <= n_try[9] ? n_shift : n_try[8:0];
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd11) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[7:0];
endmodule

// ----- rtl/mono_framebuffer_draw_engine.sv -----
// Page-mode monochrome framebuffer draw engine. One command at a time: start is taken
// while busy is low, and exactly one result word follows on o_rsp with o_valid high
// for one cycle; the receiver cannot stall it. Each plotted point takes an address,
// read and write-back step on the single-port frame memory; a clipped point skips
// the read and the write. A line first runs the slope divide; a circle plots eight
// points per step-loop pass; clear all zeroes every word. After reset a clearing
// pass over the whole memory runs with busy high.
module mono_framebuffer_draw_engine #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mfde_pkg::t_req   i_req,
    output logic             o_valid,
    output mfde_pkg::t_rsp   o_rsp
);
    import mfde_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WIPE  = 4'd1;
    localparam logic [3:0] S_GEN   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_CTEST = 4'd7;
    localparam logic [3:0] S_CSTEP = 4'd8;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    logic [3:0]  r_state;
    t_req        r_req;
    logic [AW:0] r_wcnt;
    logic        r_clip;
    logic [7:0]  r_i;         // line index / circle a
    logic [7:0]  r_b;         // circle b
    logic [2:0]  r_oct;       // circle point in pass
    logic [7:0]  r_k;
    logic [15:0] r_ik;        // i*k accumulated
    logic [AW-1:0] r_addr;
    logic [7:0]  r_mask;
    logic        r_set;
    logic        r_wren;      // write back this point
    logic [7:0]  r_data;
    logic        r_last;      // this plot ends the command
    logic        r_valid;
    t_rsp        r_rsp;

    logic [7:0]  n_px, n_py;
    logic        n_out;
    logic [AW-1:0] n_addr;
    logic [15:0] n_r2, n_b2, n_a2;
    logic [16:0] n_lhs;
    logic [16:0] n_sum;
    logic        div_go, div_done;
    logic [7:0]  div_quo;
    logic [7:0]  n_dx, n_dy;

    assign n_dx = r_req.end_x - r_req.pos_x;
    assign n_dy = r_req.end_y - r_req.pos_y;

    mfde_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (div_go),
        .i_num  (12'(n_dy) * 12'(SLOPE_SCALE)),
        .i_den  (n_dx),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // i*k/10 with i*k < 65536: reciprocal multiply is exact over 16 bits
    logic [31:0] n_q10;
    logic [7:0]  n_yoff;
    always_comb begin
        n_q10  = (32'(r_ik) * 32'd52429) >> 19;
        n_yoff = n_q10[7:0];
    end

    // circle arithmetic on current a, b
    always_comb begin
        n_r2  = 16'(r_req.radius) * 16'(r_req.radius);
        n_b2  = 16'(r_b) * 16'(r_b);
        n_a2  = 16'(r_i) * 16'(r_i);
        n_lhs = {n_b2, 1'b0};
        n_sum = 17'(n_a2) + 17'(n_b2);
    end

    // point generator
    always_comb begin
        n_px = r_req.pos_x;
        n_py = r_req.pos_y;
        if (r_req.req_type == REQ_LINE) begin
            if (r_req.pos_x == r_req.end_x) begin
                n_py = r_req.pos_y + r_i;
            end else if (r_req.pos_y == r_req.end_y) begin
                n_px = r_req.pos_x + r_i;
            end else begin
                n_px = r_req.pos_x + r_i;
                n_py = r_req.pos_y + n_yoff;
            end
        end else if (r_req.req_type == REQ_CIRCLE && r_req.radius != 8'd0) begin
            case (r_oct)
                3'd0: begin n_px = r_req.pos_x + r_i; n_py = r_req.pos_y - r_b; end
                3'd1: begin n_px = r_req.pos_x - r_i; n_py = r_req.pos_y - r_b; end
                3'd2: begin n_px = r_req.pos_x - r_i; n_py = r_req.pos_y + r_b; end
                3'd3: begin n_px = r_req.pos_x + r_i; n_py = r_req.pos_y + r_b; end
                3'd4: begin n_px = r_req.pos_x + r_b; n_py = r_req.pos_y + r_i; end
                3'd5: begin n_px = r_req.pos_x + r_b; n_py = r_req.pos_y - r_i; end
                3'd6: begin n_px = r_req.pos_x - r_b; n_py = r_req.pos_y - r_i; end
                default: begin n_px = r_req.pos_x - r_b; n_py = r_req.pos_y + r_i; end
            endcase
        end
        n_out  = (9'(n_px) >= 9'(COLUMNS)) || (5'(n_py[7:3]) >= 5'(PAGES));
        n_addr = AW'(32'(n_py[7:3]) * 32'(COLUMNS) + 32'(n_px));
    end
    // divider kicked on the first cycle of a line
    assign div_go = (r_state == S_DIV) && (r_oct == 3'd1);

    logic [7:0] n_len;     // line run length
    logic       n_line_end;
    always_comb begin
        if (r_req.pos_x == r_req.end_x) begin
            n_len = (r_req.end_y > r_req.pos_y) ? r_req.end_y - r_req.pos_y : 8'd0;
        end else begin
            n_len = (r_req.end_x > r_req.pos_x) ? r_req.end_x - r_req.pos_x : 8'd0;
        end
        n_line_end = (r_i + 8'd1 == n_len);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_addr];
        end
        if (r_state == S_WIPE) begin
            r_mem[r_wcnt[AW-1:0]] <= 8'd0;
        end else if (r_state == S_WR && r_wren) begin
            r_mem[r_addr] <= r_set ? (r_rdata | r_mask) : (r_rdata & ~r_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_wcnt  <= '0;
            r_valid <= 1'b0;
            r_clip  <= 1'b0;
            r_oct   <= '0;
            r_req   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_req;
                        r_clip <= 1'b0;
                        r_i    <= '0;
                        r_b    <= i_req.radius;
                        r_oct  <= (i_req.req_type == REQ_LINE) ? 3'd1 : 3'd0;
                        r_ik   <= '0;
                        r_data <= '0;
                        r_set  <= (i_req.req_type != REQ_CLEAR);
                        case (i_req.req_type)
                            REQ_SET, REQ_CLEAR, REQ_READ: r_state <= S_GEN;
                            REQ_WIPE: begin
                                r_wcnt  <= '0;
                                r_state <= S_WIPE;
                            end
                            REQ_LINE: begin
                                r_k     <= '0;
                                r_state <= S_DIV;
                            end
                            REQ_CIRCLE: r_state <= (i_req.radius == 8'd0) ? S_GEN
                                                                         : S_CTEST;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_WIPE: begin
                    r_wcnt <= r_wcnt + 1'b1;
                    // the pass after reset ends without a result word
                    if (r_wcnt == (AW+1)'(DEPTH - 1)) begin
                        r_state <= (r_req.req_type == REQ_WIPE) ? S_DONE : S_IDLE;
                    end
                end
                S_DIV: begin
                    if (r_req.pos_x == r_req.end_x || r_req.pos_y == r_req.end_y) begin
                        r_state <= (n_len == 8'd0) ? S_DONE : S_GEN;
                        r_oct   <= '0;
                    end else if (r_oct == 3'd1) begin
                        r_oct <= 3'd2;
                    end else if (div_done) begin
                        r_k     <= div_quo;
                        r_oct   <= '0;
                        r_state <= (n_len == 8'd0) ? S_DONE : S_GEN;
                    end
                end
                S_CTEST: begin
                    r_state <= (n_lhs >= 17'(n_r2)) ? S_GEN : S_DONE;
                end
                S_GEN: begin
                    if (r_req.req_type == REQ_READ) begin
                        r_wren <= 1'b0;
                        if (9'(r_req.pos_x) >= 9'(COLUMNS)
                            || 9'(r_req.pos_y) >= 9'(PAGES)) begin
                            r_clip  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_addr  <= AW'(32'(r_req.pos_y) * 32'(COLUMNS)
                                           + 32'(r_req.pos_x));
                            r_last  <= 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        if (r_req.req_type == REQ_LINE) begin
                            r_i  <= r_i + 8'd1;
                            r_ik <= r_ik + 16'(r_k);
                            r_last <= n_line_end;
                        end else if (r_req.req_type == REQ_CIRCLE
                                     && r_req.radius != 8'd0) begin
                            r_oct <= r_oct + 3'd1;
                            r_last <= 1'b0;
                        end else begin
                            r_last <= 1'b1;
                        end
                        r_addr <= n_addr;
                        r_mask <= 8'(1) << n_py[2:0];
                        r_wren <= !n_out;
                        if (n_out) begin
                            r_clip <= 1'b1;
                            r_state <= S_WR;
                        end else begin
                            r_state <= S_RD;
                        end
                        r_data <= {7'd0, n_out};
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_req.req_type == REQ_READ) begin
                        r_data  <= r_rdata;
                        r_state <= S_DONE;
                    end else if (r_req.req_type == REQ_CIRCLE && r_req.radius != 8'd0) begin
                        r_state <= (r_oct == 3'd0) ? S_CSTEP : S_GEN;
                    end else begin
                        r_state <= r_last ? S_DONE : S_GEN;
                    end
                end
                S_CSTEP: begin
                    if (n_sum + 17'd1 + {8'd0, r_i, 1'b1} - 17'd1 > 17'(n_r2)
                        + 17'(0)) begin
                        r_b <= r_b - 8'd1;
                    end else begin
                        r_i <= r_i + 8'd1;
                    end
                    r_state <= S_CTEST;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_rsp.read_data <= (r_req.req_type == REQ_READ && !r_clip)
                                       ? r_data : 8'd0;
                    r_rsp.clipped   <= r_clip;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // write stage skips memory when the point was clipped
    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule
